// ===== src/asd_pkg.sv =====
package asd_pkg;

   localparam int RAW_W        = 16;
   localparam int SAMPLE_SHIFT = 6;
   localparam int SCALED_W     = RAW_W - SAMPLE_SHIFT;
   localparam int DIFF_W       = SCALED_W + 1;
   localparam int THR_W        = 10;
   localparam int CMP_W        = (DIFF_W > THR_W) ? DIFF_W : THR_W;
   localparam int COUNT_W      = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = THR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SHAKE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALM_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GESTURE_MODE    = 2'd2;

   localparam logic [THR_W-1:0] SHAKE_THRESHOLD_RESET = 10'd180;
   localparam logic [THR_W-1:0] CALM_THRESHOLD_RESET  = 10'd50;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
      logic signed [RAW_W-1:0] raw_z;
      logic                    batch_start;
   } req_data_type;

   typedef struct packed {
      logic               tap;
      logic               shaking_now;
      logic [COUNT_W-1:0] count_now;
   } rsp_data_type;

   typedef struct packed {
      logic [THR_W-1:0] shake_threshold;
      logic [THR_W-1:0] calm_threshold;
      logic             gesture_mode;
   } cfg_type;

   function automatic logic [CMP_W-1:0] abs_diff(input logic signed [SCALED_W-1:0] a,
                                                 input logic signed [SCALED_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      logic [DIFF_W-1:0]        mag;
      d   = DIFF_W'(a) - DIFF_W'(b);
      mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      return CMP_W'(mag);
   endfunction

   function automatic logic two_exceed(input logic [CMP_W-1:0] dx,
                                       input logic [CMP_W-1:0] dy,
                                       input logic [CMP_W-1:0] dz,
                                       input logic [THR_W-1:0] thr);
      logic bx;
      logic by;
      logic bz;
      bx = dx > CMP_W'(thr);
      by = dy > CMP_W'(thr);
      bz = dz > CMP_W'(thr);
      return (bx && by) || (bx && bz) || (by && bz);
   endfunction

endpackage

// ===== src/asd_stream_if.sv =====
interface asd_req_if import asd_pkg::*; ();
   logic         valid;
   logic         ready;
   req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface asd_rsp_if import asd_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/asd_csr.sv =====
module asd_csr import asd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SHAKE_THRESHOLD: cfg_in.shake_threshold = csr_wdata[THR_W-1:0];
            CSR_CALM_THRESHOLD:  cfg_in.calm_threshold  = csr_wdata[THR_W-1:0];
            CSR_GESTURE_MODE:    cfg_in.gesture_mode    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shake_threshold <= SHAKE_THRESHOLD_RESET;
         cfg_ff.calm_threshold  <= CALM_THRESHOLD_RESET;
         cfg_ff.gesture_mode    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/asd_datapath.sv =====
module asd_datapath import asd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   asd_req_if.sink        req_chan,
   asd_rsp_if.source      rsp_chan
);

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_data_type s1_data_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_data_type out_data_ff;
   rsp_data_type out_data_in;

   logic signed [SCALED_W-1:0] prev_x_ff;
   logic signed [SCALED_W-1:0] prev_y_ff;
   logic signed [SCALED_W-1:0] prev_z_ff;
   logic signed [SCALED_W-1:0] prev_x_in;
   logic signed [SCALED_W-1:0] prev_y_in;
   logic signed [SCALED_W-1:0] prev_z_in;
   logic                       shaking_ff;
   logic                       shaking_in;
   logic [COUNT_W-1:0]         count_ff;
   logic [COUNT_W-1:0]         count_in;

   logic                       out_free;
   logic                       advance;
   logic                       req_accept;
   logic signed [SCALED_W-1:0] nx;
   logic signed [SCALED_W-1:0] ny;
   logic signed [SCALED_W-1:0] nz;
   logic [CMP_W-1:0]           dx;
   logic [CMP_W-1:0]           dy;
   logic [CMP_W-1:0]           dz;
   logic                       hard_shake;
   logic                       moving;
   logic                       tap;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign nx = s1_data_ff.raw_x[RAW_W-1:SAMPLE_SHIFT];
   assign ny = s1_data_ff.raw_y[RAW_W-1:SAMPLE_SHIFT];
   assign nz = s1_data_ff.raw_z[RAW_W-1:SAMPLE_SHIFT];

   assign dx = abs_diff(prev_x_ff, nx);
   assign dy = abs_diff(prev_y_ff, ny);
   assign dz = abs_diff(prev_z_ff, nz);

   assign hard_shake = two_exceed(dx, dy, dz, cfg.shake_threshold);
   assign moving     = two_exceed(dx, dy, dz, cfg.calm_threshold);

   always_comb begin
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      prev_z_in  = prev_z_ff;
      shaking_in = shaking_ff;
      count_in   = count_ff;
      tap        = 1'b0;
      if (!cfg.gesture_mode) begin
         if (!s1_data_ff.batch_start) begin
            if (!shaking_ff && hard_shake && (count_ff != '0)) begin
               tap        = 1'b1;
               shaking_in = 1'b1;
               count_in   = '0;
            end else if (hard_shake) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end else if (!moving) begin
               count_in   = '0;
               shaking_in = 1'b0;
            end
         end
         prev_x_in = nx;
         prev_y_in = ny;
         prev_z_in = nz;
      end
      out_data_in.tap         = tap;
      out_data_in.shaking_now = shaking_in;
      out_data_in.count_now   = count_in;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         shaking_ff   <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            prev_x_ff  <= prev_x_in;
            prev_y_ff  <= prev_y_in;
            prev_z_ff  <= prev_z_in;
            shaking_ff <= shaking_in;
            count_ff   <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_chan.data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

// ===== src/accel_shake_detector_unit.sv =====
// An item waits in the input register and its result in the result register.
// Throughput: one item per cycle while results are taken; the input and
// result registers let a new item enter while a finished result still waits.
// Reset is synchronous and active high; it empties both registers, clears the
// previous sample, the shaking flag and the count, and restores the thresholds.
module accel_shake_detector_unit import asd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   asd_req_if.sink               req_chan,
   asd_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   asd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   asd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   a_tap_starts_shake: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.tap |->
         rsp_chan.data.shaking_now && (rsp_chan.data.count_now == '0))
      else $error("A tap item must report shaking with a cleared count.");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("No result item may be offered straight after reset.");
`endif

endmodule
